FILE: design/directed_flow_statistics_top_defines.svh
// Assertion macros shared by the directed flow statistics checker.
// No dependencies.
`ifndef DIRECTED_FLOW_STATISTICS_TOP_DEFINES_SVH
`define DIRECTED_FLOW_STATISTICS_TOP_DEFINES_SVH
// implication checked on every clock, skipped in reset
`define DFS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define DFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: design/dfs_pkg.sv
// Directed flow statistics package: word types, state codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package dfs_pkg;
   localparam logic [5:0] TcpHdrBytes = 6'd20;
   localparam int PshBit = 3;
   localparam int UrgBit = 5;

   typedef struct packed {
      logic [15:0] pkt_len;
      logic [5:0]  ip_hdr_bytes;
      logic [7:0]  tcp_flags;
      logic [31:0] now_sec;
   } req_word_type;

   typedef struct packed {
      logic [31:0] pkt_count;
      logic [15:0] len_min;
      logic [15:0] len_max;
      logic [15:0] len_mean;
      logic [15:0] len_std;
      logic [31:0] iat_min;
      logic [31:0] iat_max;
      logic [31:0] gap_mean;
      logic [31:0] iat_std;
      logic [31:0] push_count;
      logic [31:0] urgent_count;
      logic [39:0] hdr_bytes_total;
   } rsp_word_type;

   typedef enum logic [1:0] {
      OP_DIV,
      OP_SQRT
   } op_type;

   typedef struct packed {
      logic        start;
      op_type      op;
      logic [63:0] num;
      logic [31:0] den;
   } au_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } au_sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_UPDATE,
      ST_LMEAN,
      ST_LMSQ,
      ST_LSQRT,
      ST_IMEAN,
      ST_IMSQ,
      ST_ISQRT,
      ST_WAIT,
      ST_OUT
   } state_type;
endpackage

FILE: design/dfs_if.sv
// Valid/ready channel interface carrying one word.
// Depends on no package; payload type is a parameter.
`timescale 1ns / 1ps
interface dfs_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/dfs_arith.sv
// Shared bit-serial unit: 64/32 restoring divide or 64-bit integer square root.
// Depends on dfs_pkg.
`timescale 1ns / 1ps
module dfs_arith (
   input  logic               clock,
   input  logic               reset,
   input  dfs_pkg::au_cmd_type cmd,
   output dfs_pkg::au_sts_type sts
);
   logic         busy_ff, busy_in;
   logic [6:0]   cnt_ff, cnt_in;
   dfs_pkg::op_type op_ff, op_in;
   logic [63:0]  a_ff, a_in;     // dividend / radicand shift
   logic [65:0]  r_ff, r_in;     // remainder
   logic [63:0]  q_ff, q_in;     // quotient / root
   logic [31:0]  d_ff, d_in;
   logic         done_ff, done_in;
   logic [64:0]  dtrial;
   logic [65:0]  strial;
   logic [64:0]  drem;
   logic [65:0]  srem;

   always_comb begin
      drem   = {r_ff[63:0], a_ff[63]};
      dtrial = drem - {33'd0, d_ff};
      srem   = {r_ff[63:0], a_ff[63:62]};
      strial = srem - {q_ff[63:0], 2'b01};
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      a_in    = a_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      done_in = 1'b0;
      if (!busy_ff && cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         a_in    = cmd.num;
         d_in    = cmd.den;
         r_in    = '0;
         q_in    = '0;
         cnt_in  = (cmd.op == dfs_pkg::OP_DIV) ? 7'd64 : 7'd32;
      end else if (busy_ff) begin
         case (op_ff)
            dfs_pkg::OP_DIV: begin
               a_in = {a_ff[62:0], 1'b0};
               if (!dtrial[64]) begin
                  r_in = {2'b00, dtrial[63:0]};
                  q_in = {q_ff[62:0], 1'b1};
               end else begin
                  r_in = {1'b0, drem};
                  q_in = {q_ff[62:0], 1'b0};
               end
            end
            dfs_pkg::OP_SQRT: begin
               a_in = {a_ff[61:0], 2'b00};
               if (!strial[65]) begin
                  r_in = strial;
                  q_in = {q_ff[62:0], 1'b1};
               end else begin
                  r_in = srem;
                  q_in = {q_ff[62:0], 1'b0};
               end
            end
            default: ;
         endcase
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= dfs_pkg::OP_DIV;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      a_ff <= a_in;
      r_ff <= r_in;
      q_ff <= q_in;
      d_ff <= d_in;
   end

   assign sts.done   = done_ff;
   assign sts.result = q_ff;
endmodule

FILE: design/directed_flow_statistics_top.sv
// Directed flow statistics top level: accumulators, sequencer, shared unit.
// Depends on dfs_pkg, dfs_if, dfs_arith.
`timescale 1ns / 1ps
// Usage:
//  req_ channel carries one packet word (length, IP header bytes, TCP flags,
//  arrival second). rsp_ channel returns one statistics word per packet.
//  Steps from accept to rsp_valid: square, update, then two 64-step
//  divides and one 32-step square root for the length side, the same again
//  for the gap side, then output; each unit job is started from its state,
//  runs its steps and then raises a registered done. With zero elapsed time
//  the gap side is skipped.
//  Throughput: one packet at a time. The bit-serial shared divide/sqrt unit
//  handles one quotient bit or one root bit per cycle.
//  req_ready is high only in the idle state with no word pending. The result
//  is held in an output register; while the receiver stalls, rsp_valid stays
//  high and the word holds; the next packet is taken once it is accepted.
//  Synchronous reset clears all statistics to their reset values (minimums
//  all ones, everything else zero) and drops any word in flight.
//  Per-packet special cases: zero elapsed time gives zero gap mean and
//  deviation; a negative variance clamps to zero; every sum saturates.
module directed_flow_statistics_top (
   input logic clock,
   input logic reset,
   dfs_if.sink   req,
   dfs_if.source rsp
);
   dfs_pkg::state_type state_ff, state_in;
   dfs_pkg::au_cmd_type cmd;
   dfs_pkg::au_sts_type sts;
   dfs_pkg::req_word_type pkt_ff;

   logic        seen_ff;
   logic [31:0] count_ff;
   logic [47:0] lsum_ff;
   logic [63:0] lsq_ff;
   logic [15:0] lmin_ff, lmax_ff;
   logic [31:0] first_ff, prev_ff;
   logic [31:0] gsum_ff;
   logic [63:0] gsq_ff;
   logic [31:0] gmin_ff, gmax_ff;
   logic [31:0] psh_ff, urg_ff;
   logic [39:0] hdr_ff;
   logic [31:0] lensq_ff;
   logic [63:0] gapsq_ff;
   logic [31:0] gap_ff;
   logic [63:0] mean_ff;
   logic [63:0] msq_ff;
   logic [31:0] elapsed_ff;
   logic        issued_ff;
   logic        rvalid_ff;
   dfs_pkg::rsp_word_type rsp_ff;

   // helpers
   logic [64:0] lsq_add, gsq_add;
   logic [48:0] lsum_add;
   logic [32:0] gsum_add;
   logic [40:0] hdr_add;
   logic [63:0] mm;
   logic [64:0] var_diff;
   logic [31:0] gap_now;

   assign gap_now  = pkt_ff.now_sec - prev_ff;
   assign lsq_add  = {1'b0, lsq_ff} + {33'd0, lensq_ff};
   assign gsq_add  = {1'b0, gsq_ff} + {1'b0, gapsq_ff};
   assign lsum_add = {1'b0, lsum_ff} + {33'd0, pkt_ff.pkt_len};
   assign gsum_add = {1'b0, gsum_ff} + {1'b0, gap_ff};
   assign hdr_add  = {1'b0, hdr_ff} + {35'd0, pkt_ff.ip_hdr_bytes}
                   + {35'd0, dfs_pkg::TcpHdrBytes};
   assign mm       = 64'(mean_ff[31:0]) * 64'(mean_ff[31:0]);
   assign var_diff = {1'b0, msq_ff} - {1'b0, mm};

   dfs_arith u_arith (.clock(clock), .reset(reset), .cmd(cmd), .sts(sts));

   assign req.ready = (state_ff == dfs_pkg::ST_IDLE) && !rvalid_ff;
   assign rsp.valid = rvalid_ff;
   assign rsp.data  = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      cmd.start = 1'b0;
      cmd.op    = dfs_pkg::OP_DIV;
      cmd.num   = '0;
      cmd.den   = '0;
      case (state_ff)
         dfs_pkg::ST_IDLE:   if (req.valid && req.ready) state_in = dfs_pkg::ST_SQUARE;
         dfs_pkg::ST_SQUARE: state_in = dfs_pkg::ST_UPDATE;
         dfs_pkg::ST_UPDATE: state_in = dfs_pkg::ST_LMEAN;
         dfs_pkg::ST_LMEAN: begin
            cmd.start = !issued_ff;
            cmd.num   = {16'd0, lsum_ff};
            cmd.den   = count_ff;
            if (sts.done) state_in = dfs_pkg::ST_LMSQ;
         end
         dfs_pkg::ST_LMSQ: begin
            cmd.start = !issued_ff;
            cmd.num   = lsq_ff;
            cmd.den   = count_ff;
            if (sts.done) state_in = dfs_pkg::ST_LSQRT;
         end
         dfs_pkg::ST_LSQRT: begin
            cmd.start = !issued_ff;
            cmd.op    = dfs_pkg::OP_SQRT;
            cmd.num   = var_diff[64] ? 64'd0 : var_diff[63:0];
            if (sts.done) state_in = (elapsed_ff == 32'd0) ? dfs_pkg::ST_OUT
                                                           : dfs_pkg::ST_IMEAN;
         end
         dfs_pkg::ST_IMEAN: begin
            cmd.start = !issued_ff;
            cmd.num   = {32'd0, gsum_ff};
            cmd.den   = elapsed_ff;
            if (sts.done) state_in = dfs_pkg::ST_IMSQ;
         end
         dfs_pkg::ST_IMSQ: begin
            cmd.start = !issued_ff;
            cmd.num   = gsq_ff;
            cmd.den   = elapsed_ff;
            if (sts.done) state_in = dfs_pkg::ST_ISQRT;
         end
         dfs_pkg::ST_ISQRT: begin
            cmd.start = !issued_ff;
            cmd.op    = dfs_pkg::OP_SQRT;
            cmd.num   = var_diff[64] ? 64'd0 : var_diff[63:0];
            if (sts.done) state_in = dfs_pkg::ST_OUT;
         end
         dfs_pkg::ST_WAIT:   state_in = dfs_pkg::ST_OUT;
         dfs_pkg::ST_OUT:    state_in = dfs_pkg::ST_IDLE;
         default:            state_in = dfs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dfs_pkg::ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= (state_in == state_ff) && (issued_ff || cmd.start);
      end
   end

   // packet capture and squaring (length and gap are both squared in the square state)
   always_ff @(posedge clock) begin
      if (state_ff == dfs_pkg::ST_IDLE && req.valid && req.ready) pkt_ff <= req.data;
      if (state_ff == dfs_pkg::ST_SQUARE) begin
         lensq_ff <= {16'd0, pkt_ff.pkt_len} * {16'd0, pkt_ff.pkt_len};
         gap_ff   <= gap_now;
         gapsq_ff <= 64'(gap_now) * 64'(gap_now);
      end
   end

   // statistic registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         count_ff <= '0;
         lsum_ff  <= '0;
         lsq_ff   <= '0;
         lmin_ff  <= '1;
         lmax_ff  <= '0;
         first_ff <= '0;
         prev_ff  <= '0;
         gsum_ff  <= '0;
         gsq_ff   <= '0;
         gmin_ff  <= '1;
         gmax_ff  <= '0;
         psh_ff   <= '0;
         urg_ff   <= '0;
         hdr_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (state_ff == dfs_pkg::ST_UPDATE) begin
            if (count_ff != '1) count_ff <= count_ff + 32'd1;
            lsum_ff <= lsum_add[48] ? '1 : lsum_add[47:0];
            lsq_ff  <= lsq_add[64] ? '1 : lsq_add[63:0];
            if (pkt_ff.pkt_len < lmin_ff) lmin_ff <= pkt_ff.pkt_len;
            if (pkt_ff.pkt_len > lmax_ff) lmax_ff <= pkt_ff.pkt_len;
            if (!seen_ff) begin
               seen_ff  <= 1'b1;
               first_ff <= pkt_ff.now_sec;
            end else begin
               gsum_ff <= gsum_add[32] ? '1 : gsum_add[31:0];
               gsq_ff  <= gsq_add[64] ? '1 : gsq_add[63:0];
               if (gap_ff < gmin_ff) gmin_ff <= gap_ff;
               if (gap_ff > gmax_ff) gmax_ff <= gap_ff;
            end
            prev_ff <= pkt_ff.now_sec;
            if (pkt_ff.tcp_flags[dfs_pkg::PshBit] && psh_ff != '1) psh_ff <= psh_ff + 32'd1;
            if (pkt_ff.tcp_flags[dfs_pkg::UrgBit] && urg_ff != '1) urg_ff <= urg_ff + 32'd1;
            hdr_ff <= hdr_add[40] ? '1 : hdr_add[39:0];
         end
         if (state_ff == dfs_pkg::ST_OUT) rvalid_ff <= 1'b1;
         else if (rsp.ready) rvalid_ff <= 1'b0;
      end
   end

   // elapsed time, means and results
   always_ff @(posedge clock) begin
      if (state_ff == dfs_pkg::ST_UPDATE)
         elapsed_ff <= seen_ff ? (pkt_ff.now_sec - first_ff) : 32'd0;
      if (sts.done) begin
         case (state_ff)
            dfs_pkg::ST_LMEAN: begin
               mean_ff <= (sts.result > 64'd65535) ? 64'd65535 : sts.result;
               rsp_ff.len_mean <= (sts.result > 64'd65535) ? 16'hFFFF : sts.result[15:0];
            end
            dfs_pkg::ST_LMSQ:  msq_ff <= sts.result;
            dfs_pkg::ST_LSQRT: begin
               rsp_ff.len_std <= (sts.result > 64'd65535) ? 16'hFFFF : sts.result[15:0];
               mean_ff <= '0;
               rsp_ff.gap_mean <= '0;
               rsp_ff.iat_std  <= '0;
            end
            dfs_pkg::ST_IMEAN: begin
               mean_ff <= sts.result;
               rsp_ff.gap_mean <= sts.result[31:0];
            end
            dfs_pkg::ST_IMSQ:  msq_ff <= sts.result;
            dfs_pkg::ST_ISQRT: rsp_ff.iat_std <= sts.result[31:0];
            default: ;
         endcase
      end
      if (state_ff == dfs_pkg::ST_OUT) begin
         rsp_ff.pkt_count       <= count_ff;
         rsp_ff.len_min         <= lmin_ff;
         rsp_ff.len_max         <= lmax_ff;
         rsp_ff.iat_min         <= gmin_ff;
         rsp_ff.iat_max         <= gmax_ff;
         rsp_ff.push_count      <= psh_ff;
         rsp_ff.urgent_count    <= urg_ff;
         rsp_ff.hdr_bytes_total <= hdr_ff;
      end
   end
endmodule

FILE: design/dfs_checker.sv
// Port-level checker for the directed flow statistics block, with bind.
// Depends on dfs_pkg and directed_flow_statistics_top_defines.svh.
`timescale 1ns / 1ps
`include "directed_flow_statistics_top_defines.svh"
module dfs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input dfs_pkg::rsp_word_type rsp_data
);
   `DFS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   `DFS_ASSERT_IMPL(a_no_ready_while_rsp, clock, reset, rsp_valid, !req_ready, "ready with pending word")
   `DFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "word dropped")
   `DFS_ASSERT_IMPL(a_min_max, clock, reset, rsp_valid, rsp_data.len_min <= rsp_data.len_max, "min above max")
endmodule

bind directed_flow_statistics_top dfs_checker u_dfs_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));

FILE: sim/testbench.sv
// Self-checking bench for directed_flow_statistics_top: drives packet words,
// predicts each statistics word and checks it. Depends on dfs_pkg, dfs_if, RTL.
`timescale 1ns / 1ps
module testbench;
   localparam int RandomPackets = 600;
   localparam int DrainCycles = 400;   // a bit over one packet's latency
   localparam int HoldStart = 20000;   // receiver holds off from this cycle
   localparam int HoldCycles = 3000;
   localparam int CalmStart = 60000;   // no idling on either side in here
   localparam int CalmEnd = 90000;

   logic clock;
   logic reset;

   dfs_if #(.word_type(dfs_pkg::req_word_type)) req_ch ();
   dfs_if #(.word_type(dfs_pkg::rsp_word_type)) rsp_ch ();

   directed_flow_statistics_top dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   // packets waiting to go in, statistics words waiting to come out
   dfs_pkg::req_word_type packet_queue[$];
   dfs_pkg::rsp_word_type stats_queue[$];
   int unsigned cycle_count;
   int unsigned mismatch_count;
   bit stimulus_loaded;

   // flow state mirrored from the block
   bit seen_first;
   logic [31:0] pkt_total;
   logic [47:0] len_sum;
   logic [63:0] len_sq_sum;
   logic [15:0] len_low;
   logic [15:0] len_high;
   logic [31:0] start_sec;
   logic [31:0] last_sec;
   logic [31:0] gap_sum;
   logic [63:0] gap_sq_sum;
   logic [31:0] gap_low;
   logic [31:0] gap_high;
   logic [31:0] push_total;
   logic [31:0] urgent_total;
   logic [39:0] header_total;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] probe;
      root = '0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // floor deviation: sqrt(sq/div - mean^2), clamped at zero
   function automatic logic [63:0] spread(logic [63:0] sq, logic [63:0] div,
                                          logic [63:0] mean);
      logic [63:0] mean_sq;
      logic [63:0] mean_of_sq;
      if (div == 0) return '0;
      mean_of_sq = sq / div;
      mean_sq = mean * mean;
      if (mean_of_sq <= mean_sq) return '0;
      return int_sqrt(mean_of_sq - mean_sq);
   endfunction

   // fold one packet into the flow state and return the statistics word
   function automatic dfs_pkg::rsp_word_type fold_packet(dfs_pkg::req_word_type p);
      dfs_pkg::rsp_word_type s;
      logic [48:0] wide48;
      logic [64:0] wide64;
      logic [32:0] wide32;
      logic [40:0] wide40;
      logic [31:0] gap;
      logic [31:0] elapsed;
      logic [63:0] mean;
      logic [63:0] dev;
      if (pkt_total != '1) pkt_total = pkt_total + 1;
      wide48 = len_sum + p.pkt_len;
      len_sum = wide48[48] ? '1 : wide48[47:0];
      wide64 = len_sq_sum + 64'(p.pkt_len) * 64'(p.pkt_len);
      len_sq_sum = wide64[64] ? '1 : wide64[63:0];
      if (p.pkt_len < len_low) len_low = p.pkt_len;
      if (p.pkt_len > len_high) len_high = p.pkt_len;
      if (!seen_first) begin
         // first packet only marks the start time
         seen_first = 1'b1;
         start_sec = p.now_sec;
      end else begin
         gap = p.now_sec - last_sec;   // wraps when time runs backwards
         wide32 = gap_sum + gap;
         gap_sum = wide32[32] ? '1 : wide32[31:0];
         wide64 = gap_sq_sum + 64'(gap) * 64'(gap);
         gap_sq_sum = wide64[64] ? '1 : wide64[63:0];
         if (gap < gap_low) gap_low = gap;
         if (gap > gap_high) gap_high = gap;
      end
      last_sec = p.now_sec;
      if (p.tcp_flags[dfs_pkg::PshBit] && push_total != '1) push_total = push_total + 1;
      if (p.tcp_flags[dfs_pkg::UrgBit] && urgent_total != '1)
         urgent_total = urgent_total + 1;
      wide40 = header_total + p.ip_hdr_bytes + 40'd20;
      header_total = wide40[40] ? '1 : wide40[39:0];

      mean = len_sum / pkt_total;
      if (mean > 65535) mean = 65535;
      dev = spread(len_sq_sum, pkt_total, mean);
      if (dev > 65535) dev = 65535;
      s.len_mean = mean[15:0];
      s.len_std = dev[15:0];
      elapsed = p.now_sec - start_sec;
      s.gap_mean = '0;
      s.iat_std = '0;
      if (elapsed != 0) begin
         mean = gap_sum / elapsed;
         s.gap_mean = mean[31:0];
         dev = spread(gap_sq_sum, elapsed, mean);
         s.iat_std = dev[31:0];
      end
      s.pkt_count = pkt_total;
      s.len_min = len_low;
      s.len_max = len_high;
      s.iat_min = gap_low;
      s.iat_max = gap_high;
      s.push_count = push_total;
      s.urgent_count = urgent_total;
      s.hdr_bytes_total = header_total;
      return s;
   endfunction

   function automatic dfs_pkg::req_word_type packet(logic [15:0] len, logic [5:0] hdr,
                                                    logic [7:0] flags, logic [31:0] sec);
      dfs_pkg::req_word_type p;
      p.pkt_len = len;
      p.ip_hdr_bytes = hdr;
      p.tcp_flags = flags;
      p.now_sec = sec;
      return p;
   endfunction

   function automatic bit calm();
      return cycle_count >= CalmStart && cycle_count < CalmEnd;
   endfunction

   // stimulus: directed packets, then a random flow
   initial begin
      dfs_pkg::req_word_type p;
      logic [31:0] sec;
      int pick;
      seen_first = 1'b0;
      pkt_total = '0;
      len_sum = '0;
      len_sq_sum = '0;
      len_low = 16'hFFFF;
      len_high = '0;
      start_sec = '0;
      last_sec = '0;
      gap_sum = '0;
      gap_sq_sum = '0;
      gap_low = '1;
      gap_high = '0;
      push_total = '0;
      urgent_total = '0;
      header_total = '0;
      stimulus_loaded = 1'b0;

      // first packet, no gap yet; zero elapsed on the second one
      packet_queue.push_back(packet(16'd0, 6'd0, 8'h00, 32'd1000));
      packet_queue.push_back(packet(16'hFFFF, 6'd63, 8'hFF, 32'd1000));
      packet_queue.push_back(packet(16'd40, 6'd20, 8'h08, 32'd1001));
      packet_queue.push_back(packet(16'd1500, 6'd60, 8'h20, 32'd1003));
      packet_queue.push_back(packet(16'd1500, 6'd20, 8'h28, 32'd1003));
      // time running backwards gives a huge wrapped gap
      packet_queue.push_back(packet(16'd576, 6'd24, 8'hD7, 32'd500));
      packet_queue.push_back(packet(16'd60, 6'd42, 8'h10, 32'hFFFF_FFFF));
      // gap sum stays saturated here
      packet_queue.push_back(packet(16'hFFFF, 6'd21, 8'h02, 32'hFFFF_FFFE));
      packet_queue.push_back(packet(16'd1, 6'd0, 8'h01, 32'd0));
      packet_queue.push_back(packet(16'h8000, 6'h2A, 8'h55, 32'hAAAA_AAAA));
      packet_queue.push_back(packet(16'h7FFF, 6'h15, 8'hAA, 32'h5555_5555));
      packet_queue.push_back(packet(16'd1234, 6'd33, 8'h04, 32'h5555_5556));

      sec = $urandom;
      repeat (RandomPackets) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) sec = sec + $urandom_range(0, 4);
         else if (pick < 95) sec = sec + $urandom_range(0, 100000);
         else sec = $urandom;
         p.now_sec = sec;
         pick = $urandom_range(0, 9);
         p.pkt_len = pick == 0 ? 16'hFFFF : pick == 1 ? 16'd0 :
                     pick < 6 ? 16'($urandom_range(40, 1500)) : 16'($urandom);
         p.ip_hdr_bytes = $urandom_range(0, 9) == 0 ? 6'($urandom) :
                          6'($urandom_range(20, 60));
         p.tcp_flags = 8'($urandom);
         packet_queue.push_back(p);
      end
      stimulus_loaded = 1'b1;
   end

   // packet driver
   always @(posedge clock) begin
      bit accepted;
      accepted = req_ch.valid && req_ch.ready;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (accepted) begin
            stats_queue.push_back(fold_packet(req_ch.data));
            void'(packet_queue.pop_front());
         end
         if (!req_ch.valid || accepted) begin
            if (packet_queue.size() > 0 && (calm() || $urandom_range(0, 99) >= 30)) begin
               req_ch.valid <= 1'b1;
               req_ch.data <= packet_queue[0];
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // statistics word receiver, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= HoldStart && cycle_count < HoldStart + HoldCycles)
            rsp_ch.ready <= 1'b0;
         else
            rsp_ch.ready <= calm() || $urandom_range(0, 99) >= 30;
      end
   end

   // checker
   always @(posedge clock) begin
      dfs_pkg::rsp_word_type want;
      dfs_pkg::rsp_word_type got;
      string bad;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (stats_queue.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
               $display("unexpected statistics word %p", got);
         end else begin
            want = stats_queue.pop_front();
            bad = "";
            if (got.pkt_count !== want.pkt_count) bad = {bad, " pkt_count"};
            if (got.len_min !== want.len_min) bad = {bad, " len_min"};
            if (got.len_max !== want.len_max) bad = {bad, " len_max"};
            if (got.len_mean !== want.len_mean) bad = {bad, " len_mean"};
            if (got.len_std !== want.len_std) bad = {bad, " len_std"};
            if (got.iat_min !== want.iat_min) bad = {bad, " iat_min"};
            if (got.iat_max !== want.iat_max) bad = {bad, " iat_max"};
            if (got.gap_mean !== want.gap_mean) bad = {bad, " gap_mean"};
            if (got.iat_std !== want.iat_std) bad = {bad, " iat_std"};
            if (got.push_count !== want.push_count) bad = {bad, " push_count"};
            if (got.urgent_count !== want.urgent_count) bad = {bad, " urgent_count"};
            if (got.hdr_bytes_total !== want.hdr_bytes_total)
               bad = {bad, " hdr_bytes_total"};
            if (bad != "") begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) begin
                  $display("mismatch in%s", bad);
                  $display("  expected %p", want);
                  $display("  actual   %p", got);
               end
            end
         end
      end
   end

   // reset, then wait for every word to come back
   initial begin
      mismatch_count = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_loaded && packet_queue.size() == 0 && stats_queue.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && stats_queue.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #8ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
